[rtl/core/sfdn_pkg.sv]
// Shared constants for the SBUS frame decoder and stick normalizer.
package sfdn_pkg;

  localparam int OUT_FRAC_BITS = 14;

  localparam int CH_W       = 11;
  localparam int BYTE_W     = 8;
  localparam int POS_W      = 5;
  localparam int USED_CH    = 5;
  localparam int USED_BITS  = USED_CH * CH_W;
  localparam int PAYBITS_W  = $clog2(USED_BITS + 1);

  localparam logic [BYTE_W-1:0] HEADER_BYTE  = 8'h0F;
  localparam logic [POS_W-1:0]  PAYLOAD_LAST = 5'd22;
  localparam logic [POS_W-1:0]  LAST_POS     = 5'd24;

  localparam logic [CH_W-1:0] CENTER_RST = 11'd992;
  localparam logic [CH_W-1:0] TMIN_RST   = 11'd172;
  localparam logic [CH_W-1:0] SMAX_RST   = 11'd1811;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam logic [1:0] REG_CENTER = 2'd0;
  localparam logic [1:0] REG_TMIN   = 2'd1;
  localparam logic [1:0] REG_SMAX   = 2'd2;

  localparam int OUT_DW = 80;

endpackage

[rtl/core/sbus_frame_decoder_normalizer_top.sv]
// SBUS frame decoder top level: bit-serial channel unpack and serial normalizing divider.
// Takes one received byte per item and counts bytes into 25-byte frames with no
// resynchronization; byte 0 must be 0x0F for the frame to count. A header or trailer
// byte is taken directly; a payload byte's bits walk one per cycle, those of the
// used channels into the channel shift register. On the 25th byte one result item
// is given: for a good frame roll, pitch, yaw, throttle and mode are worked out one
// after another by a single restoring divider that makes one quotient bit per cycle;
// a value on its zero point or at or beyond full scale skips the divide. A bad frame
// gives a zero result with frame_ok low. The result waits in an output register
// while the next frame's bytes are taken; only the closing byte of the following
// frame stalls until it is gone. Calibration registers are written over the APB port.
module sbus_frame_decoder_normalizer_top #(
  parameter int OUT_FRAC_BITS = sfdn_pkg::OUT_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,    // [7:0] rx_byte
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [15:0] roll_norm, [31:16] pitch_norm, [47:32] yaw_norm,
  // [62:48] throttle_norm, [77:63] mode_norm, [79:78] zero
  output logic [sfdn_pkg::OUT_DW-1:0] out_tdata,
  output logic                        out_tuser,   // [0] frame_ok
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [sfdn_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [sfdn_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [sfdn_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  localparam int CW   = sfdn_pkg::CH_W;
  localparam int QW   = OUT_FRAC_BITS + 1;
  localparam int RW   = OUT_FRAC_BITS + 2;
  localparam int CNTW = $clog2(QW + 1);
  localparam int UB   = sfdn_pkg::USED_BITS;
  localparam int PBW  = sfdn_pkg::PAYBITS_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SHIFT = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_RUN   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  localparam logic [2:0] SLOT_ROLL  = 3'd0;
  localparam logic [2:0] SLOT_PITCH = 3'd1;
  localparam logic [2:0] SLOT_YAW   = 3'd2;
  localparam logic [2:0] SLOT_THR   = 3'd3;
  localparam logic [2:0] SLOT_MODE  = 3'd4;

  logic [2:0]               st_r, st_nxt;
  logic [sfdn_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic                     hdr_r, hdr_nxt;
  logic [PBW-1:0]           paybits_r, paybits_nxt;
  logic [2:0]               bitcnt_r, bitcnt_nxt;
  logic [7:0]               byte_r, byte_nxt;
  logic [UB-1:0]            ch_r, ch_nxt;
  logic [2:0]               slot_r, slot_nxt;
  logic [CNTW-1:0]          cnt_r, cnt_nxt;
  logic [CW-1:0]            rem_r, rem_nxt;
  logic [CW-1:0]            ad_r, ad_nxt;
  logic                     neg_r, neg_nxt;
  logic [QW-1:0]            q_r, q_nxt;
  logic [15:0]              roll_r, roll_nxt, pitch_r, pitch_nxt, yaw_r, yaw_nxt;
  logic [14:0]              thr_r, thr_nxt, mode_r, mode_nxt;
  logic                     ok_r, ok_nxt;
  logic                     ovld_r, ovld_nxt;
  logic [CW-1:0]            center_r, tmin_r, smax_r;

  logic                     in_acc, cfg_wr;
  logic [CW-1:0]            sel_v, sel_z;
  logic [CW:0]              num, den;
  logic [CW-1:0]            an, ad;
  logic [CW:0]              two_rem;
  logic                     ge;
  logic [QW:0]              mag_w;
  logic signed [RW-1:0]     magx, res;
  logic signed [31:0]       res32;

  assign in_tready  = (st_r == ST_IDLE) && !(ovld_r && pos_r == sfdn_pkg::LAST_POS);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = ovld_r;
  assign out_tuser  = ok_r;
  assign out_tdata  = {2'b00, mode_r, thr_r, yaw_r, pitch_r, roll_r};
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_paddr[3:2])
      sfdn_pkg::REG_CENTER: cfg_prdata = 32'(center_r);
      sfdn_pkg::REG_TMIN:   cfg_prdata = 32'(tmin_r);
      sfdn_pkg::REG_SMAX:   cfg_prdata = 32'(smax_r);
      default:              cfg_prdata = '0;
    endcase
  end

  // operand select for the current output slot
  always_comb begin
    sel_z = center_r;
    case (slot_r)
      SLOT_ROLL:  sel_v = ch_r[0*CW +: CW];
      SLOT_PITCH: sel_v = ch_r[1*CW +: CW];
      SLOT_YAW:   sel_v = ch_r[3*CW +: CW];
      SLOT_THR: begin
        sel_v = ch_r[2*CW +: CW];
        sel_z = tmin_r;
      end
      SLOT_MODE:  sel_v = ch_r[4*CW +: CW];
      default:    sel_v = '0;
    endcase
  end

  assign num = {1'b0, sel_v} - {1'b0, sel_z};
  assign den = {1'b0, smax_r} - {1'b0, sel_z};
  assign an  = num[CW] ? CW'(-num) : num[CW-1:0];
  assign ad  = den[CW] ? CW'(-den) : den[CW-1:0];

  assign two_rem = {rem_r, 1'b0};
  assign ge      = two_rem >= {1'b0, ad_r};

  // round half away from zero on the magnitude: quotient carries one extra fraction bit
  assign mag_w = (QW+1)'(q_r) + (QW+1)'(1);
  assign magx  = {1'b0, mag_w[QW:1]};

  always_comb begin
    res = neg_r ? -magx : magx;
    if (neg_r && (slot_r == SLOT_THR || slot_r == SLOT_MODE)) begin
      res = '0;
    end
  end

  assign res32 = 32'(res);

  always_comb begin
    st_nxt      = st_r;
    pos_nxt     = pos_r;
    hdr_nxt     = hdr_r;
    paybits_nxt = paybits_r;
    bitcnt_nxt  = bitcnt_r;
    byte_nxt    = byte_r;
    ch_nxt      = ch_r;
    slot_nxt    = slot_r;
    cnt_nxt     = cnt_r;
    rem_nxt     = rem_r;
    ad_nxt      = ad_r;
    neg_nxt     = neg_r;
    q_nxt       = q_r;
    roll_nxt    = roll_r;
    pitch_nxt   = pitch_r;
    yaw_nxt     = yaw_r;
    thr_nxt     = thr_r;
    mode_nxt    = mode_r;
    ok_nxt      = ok_r;
    ovld_nxt    = ovld_r;

    if (ovld_r && out_tready) begin
      ovld_nxt = 1'b0;
    end

    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          pos_nxt = pos_r + 1'b1;
          if (pos_r == '0) begin
            hdr_nxt     = (in_tdata == sfdn_pkg::HEADER_BYTE);
            paybits_nxt = '0;
          end else if (pos_r <= sfdn_pkg::PAYLOAD_LAST) begin
            byte_nxt   = in_tdata;
            bitcnt_nxt = '0;
            st_nxt     = ST_SHIFT;
          end else if (pos_r == sfdn_pkg::LAST_POS) begin
            pos_nxt = '0;
            if (hdr_r) begin
              slot_nxt = SLOT_ROLL;
              st_nxt   = ST_LOAD;
            end else begin
              roll_nxt  = '0;
              pitch_nxt = '0;
              yaw_nxt   = '0;
              thr_nxt   = '0;
              mode_nxt  = '0;
              ok_nxt    = 1'b0;
              ovld_nxt  = 1'b1;
            end
          end
        end
      end
      ST_SHIFT: begin
        if (hdr_r && paybits_r < PBW'(UB)) begin
          ch_nxt      = {byte_r[0], ch_r[UB-1:1]};
          paybits_nxt = paybits_r + 1'b1;
        end
        byte_nxt   = {1'b0, byte_r[7:1]};
        bitcnt_nxt = bitcnt_r + 1'b1;
        if (bitcnt_r == 3'd7) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_LOAD: begin
        neg_nxt = num[CW] ^ den[CW];
        ad_nxt  = ad;
        rem_nxt = an;
        cnt_nxt = CNTW'(QW);
        q_nxt   = '0;
        if (an == '0) begin
          st_nxt = ST_FIN;
        end else if (an >= ad) begin
          // at or beyond full scale, also covers a zero span
          q_nxt  = '1;
          st_nxt = ST_FIN;
        end else begin
          st_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        rem_nxt = ge ? CW'(two_rem - {1'b0, ad_r}) : two_rem[CW-1:0];
        q_nxt   = {q_r[QW-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          st_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        case (slot_r)
          SLOT_ROLL:  roll_nxt  = res32[15:0];
          SLOT_PITCH: pitch_nxt = res32[15:0];
          SLOT_YAW:   yaw_nxt   = res32[15:0];
          SLOT_THR:   thr_nxt   = res32[14:0];
          default:    mode_nxt  = res32[14:0];
        endcase
        if (slot_r == SLOT_MODE) begin
          ok_nxt   = 1'b1;
          ovld_nxt = 1'b1;
          st_nxt   = ST_IDLE;
        end else begin
          slot_nxt = slot_r + 1'b1;
          st_nxt   = ST_LOAD;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      pos_r     <= '0;
      hdr_r     <= 1'b0;
      paybits_r <= '0;
      bitcnt_r  <= '0;
      slot_r    <= SLOT_ROLL;
      cnt_r     <= '0;
      ovld_r    <= 1'b0;
      ok_r      <= 1'b0;
      center_r  <= sfdn_pkg::CENTER_RST;
      tmin_r    <= sfdn_pkg::TMIN_RST;
      smax_r    <= sfdn_pkg::SMAX_RST;
    end else begin
      st_r      <= st_nxt;
      pos_r     <= pos_nxt;
      hdr_r     <= hdr_nxt;
      paybits_r <= paybits_nxt;
      bitcnt_r  <= bitcnt_nxt;
      slot_r    <= slot_nxt;
      cnt_r     <= cnt_nxt;
      ovld_r    <= ovld_nxt;
      ok_r      <= ok_nxt;
      if (cfg_wr) begin
        case (cfg_paddr[3:2])
          sfdn_pkg::REG_CENTER: center_r <= cfg_pwdata[CW-1:0];
          sfdn_pkg::REG_TMIN:   tmin_r   <= cfg_pwdata[CW-1:0];
          sfdn_pkg::REG_SMAX:   smax_r   <= cfg_pwdata[CW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    ch_r    <= ch_nxt;
    rem_r   <= rem_nxt;
    ad_r    <= ad_nxt;
    neg_r   <= neg_nxt;
    q_r     <= q_nxt;
    roll_r  <= roll_nxt;
    pitch_r <= pitch_nxt;
    yaw_r   <= yaw_nxt;
    thr_r   <= thr_nxt;
    mode_r  <= mode_nxt;
  end

  a_no_result_during_div: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_LOAD || st_r == ST_RUN || st_r == ST_FIN) |-> !ovld_r)
    else $error("result pending while divider overwrites it");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RUN) |-> (rem_r < ad_r))
    else $error("divider remainder not below divisor");

  a_bad_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && !ok_r) |-> (out_tdata == '0))
    else $error("bad frame result carries nonzero data");

  a_result_at_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovld_r) |-> (pos_r == '0))
    else $error("result raised away from frame boundary");

endmodule
